/* hw/rtl/sps_pkg.sv */
`timescale 1ns / 1ps

package sps_pkg;

    // Fixed field widths of the command and result items.
    localparam int OPCODE_W  = 2;
    localparam int OPERAND_W = 17;
    localparam int NUMBER_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int LEN_W     = 17;

    // Bitmap storage is organised as words of candidate bits.
    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;

    localparam int SEGMENT_DEPTH_DEF = 65536;

    // Register reset values.
    localparam logic [NUMBER_W-1:0] BASE_RST   = '0;
    localparam logic [LEN_W-1:0]    LENGTH_RST = 17'd65536;
    localparam logic [LEN_W-1:0]    ROOT_RST   = 17'd256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_STRIKE = 2'd1,
        OP_READ   = 2'd2,
        OP_FIND   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_SETUP,
        ST_SRD,
        ST_SWR,
        ST_RRD,
        ST_RCHK,
        ST_FRD,
        ST_FCHK,
        ST_PUT
    } t_state;

    // Status of the remainder unit as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_rem_stat;

endpackage

/* hw/rtl/segmented_prime_sieve.sv */
`timescale 1ns / 1ps

// Segmented sieve of Eratosthenes over one segment of integers.
// Requests arrive on the slave stream: tuser carries the opcode (clear,
// strike prime, read entry, find next candidate), tdata the operand.
// Every request gives one result on the master stream: tdata holds the
// absolute number, tuser the hit and status flags.
// Configuration (segment base, length, root limit) is written through the
// cfg channel, which is always ready; write it only while the block is idle.
// Sequencer steps per request, from acceptance to the result becoming valid:
//   read: a memory read, then a check; rejected operand: straight to the result;
//   clear: a pass over the bitmap, one bitmap word written per cycle;
//   strike: the 32-step remainder unit, a setup step, then a read-modify-write
//           of the bitmap memory for each multiple;
//   find: one memory read and check per bitmap word scanned, and one more read
//         when the search stops at the segment end or root limit.
// After reset the bitmap is set to all candidates by a pass over every word of
// the memory; no request is taken meanwhile.
// The result waits in an output register while the receiver stalls; the next
// request is taken meanwhile, and its result is held until the register frees.
module segmented_prime_sieve #(
    parameter int SEGMENT_DEPTH = sps_pkg::SEGMENT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [23:0]                     i_s_tdata,   // [16:0] operand
    input  logic [1:0]                      i_s_tuser,   // [1:0] opcode
    // Result stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [31:0]                     o_m_tdata,   // [31:0] number
    output logic [1:0]                      o_m_tuser,   // [0] hit, [1] status
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sps_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = $clog2(SEGMENT_DEPTH);
    localparam int POS_W  = (IDX_W + 1 > 18) ? IDX_W + 1 : 18;
    localparam int WORDS  = (SEGMENT_DEPTH + sps_pkg::WORD_BITS - 1) / sps_pkg::WORD_BITS;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int WB     = sps_pkg::WORD_BITS;
    localparam int WS     = sps_pkg::WORD_SHIFT;
    localparam int OW     = sps_pkg::OPERAND_W;
    localparam int NW     = sps_pkg::NUMBER_W;
    localparam int SQ_W   = 2 * OW;
    localparam int ST_W   = SQ_W + 1;

    localparam logic [POS_W-1:0]  DEPTH_P   = POS_W'(SEGMENT_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

    sps_pkg::t_state     r_state;
    sps_pkg::t_state     n_state;
    sps_pkg::t_opcode    w_op;
    sps_pkg::t_rem_stat  w_rem_stat;

    // Bitmap memory and its registered read port.
    logic [WB-1:0]       r_map [WORDS];
    logic [WB-1:0]       r_rdata;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [WB-1:0]       w_wdata;
    logic [ADDR_W-1:0]   w_raddr;

    // Configuration registers.
    logic [NW-1:0]       r_base;
    logic [sps_pkg::LEN_W-1:0] r_seg_len;
    logic [sps_pkg::LEN_W-1:0] r_root;

    // Request and working registers.
    logic [OW-1:0]       r_arg;
    logic [POS_W-1:0]    r_pos;
    logic [ADDR_W-1:0]   r_addr;
    logic [SQ_W-1:0]     r_sq;
    logic [OW-1:0]       r_first;
    logic [NW-1:0]       r_res_num;
    logic                r_res_hit;
    logic                r_res_stat;

    // Output register.
    logic                r_out_valid;
    logic [NW-1:0]       r_out_num;
    logic                r_out_hit;
    logic                r_out_stat;

    logic                w_accept;
    logic                w_put;
    logic                w_sweep_last;
    logic                w_rem_start;
    logic [OW-1:0]       w_rem;
    logic [POS_W-1:0]    w_cfg_len;
    logic [POS_W-1:0]    w_len;
    logic [POS_W-1:0]    w_arg;
    logic                w_arg_bad;
    logic [ST_W-1:0]     w_diff;
    logic [ST_W-1:0]     w_start;
    logic [POS_W-1:0]    w_next_pos;
    logic [POS_W-1:0]    w_word_next;
    logic [NW:0]         w_abs;
    logic                w_over_root;
    logic                w_base_zero;
    logic [WB-1:0]       w_masked;
    logic                w_any;
    logic [WS-1:0]       w_off;
    logic [POS_W-1:0]    w_cand;
    logic [NW:0]         w_cand_abs;
    logic                w_cand_ok;

    assign w_op        = sps_pkg::t_opcode'(i_s_tuser);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_put       = (r_state == sps_pkg::ST_PUT) && (!r_out_valid || i_m_tready);
    assign w_sweep_last = (r_addr == LAST_ADDR);
    assign o_cfg_ready = 1'b1;

    // Segment length in use, clipped to the bitmap depth.
    assign w_cfg_len = POS_W'(r_seg_len);
    assign w_len     = (w_cfg_len > DEPTH_P) ? DEPTH_P : w_cfg_len;
    assign w_arg     = POS_W'(i_s_tdata[OW-1:0]);
    assign w_arg_bad = (w_arg >= w_len);

    // Strike start: the larger of the first multiple at or above base and p squared.
    always_comb begin
        w_diff  = ST_W'(r_sq) - ST_W'(r_base);
        w_start = ST_W'(r_first);
        if ((r_sq > SQ_W'(r_base)) && (w_diff > ST_W'(r_first))) begin
            w_start = w_diff;
        end
    end

    assign w_next_pos  = r_pos + POS_W'(r_arg);
    assign w_word_next = (r_pos | POS_W'(WB - 1)) + 1'b1;
    assign w_base_zero = (r_base == '0);
    assign w_abs       = (NW + 1)'(r_base) + (NW + 1)'(r_pos);
    assign w_over_root = (w_abs > (NW + 1)'(r_root));

    // Candidate search within one bitmap word: lowest set bit at or above r_pos.
    always_comb begin
        w_masked = r_rdata & ({WB{1'b1}} << r_pos[WS-1:0]);
        if (w_base_zero && (r_pos[POS_W-1:WS] == '0)) begin
            w_masked = w_masked & ~WB'(3);
        end
        w_any = |w_masked;
        w_off = '0;
        for (int k = WB - 1; k >= 0; k--) begin
            if (w_masked[k]) begin
                w_off = WS'(k);
            end
        end
        w_cand     = {r_pos[POS_W-1:WS], w_off};
        w_cand_abs = (NW + 1)'(r_base) + (NW + 1)'(w_cand);
        w_cand_ok  = (w_cand < w_len) && (w_cand_abs <= (NW + 1)'(r_root));
    end

    // Next-state logic of the command sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sps_pkg::ST_INIT: begin
                if (w_sweep_last) n_state = sps_pkg::ST_IDLE;
            end
            sps_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        sps_pkg::OP_CLEAR: n_state = sps_pkg::ST_CLEAR;
                        sps_pkg::OP_STRIKE: begin
                            n_state = (w_arg < POS_W'(2)) ? sps_pkg::ST_PUT : sps_pkg::ST_DIV;
                        end
                        sps_pkg::OP_READ: begin
                            n_state = w_arg_bad ? sps_pkg::ST_PUT : sps_pkg::ST_RRD;
                        end
                        sps_pkg::OP_FIND: begin
                            n_state = w_arg_bad ? sps_pkg::ST_PUT : sps_pkg::ST_FRD;
                        end
                        default: n_state = sps_pkg::ST_PUT;
                    endcase
                end
            end
            sps_pkg::ST_CLEAR: begin
                if (w_sweep_last) n_state = sps_pkg::ST_PUT;
            end
            sps_pkg::ST_DIV: begin
                if (w_rem_stat.done) n_state = sps_pkg::ST_SETUP;
            end
            sps_pkg::ST_SETUP: begin
                n_state = (w_start >= ST_W'(w_len)) ? sps_pkg::ST_PUT : sps_pkg::ST_SRD;
            end
            sps_pkg::ST_SRD:  n_state = sps_pkg::ST_SWR;
            sps_pkg::ST_SWR: begin
                n_state = (w_next_pos >= w_len) ? sps_pkg::ST_PUT : sps_pkg::ST_SRD;
            end
            sps_pkg::ST_RRD:  n_state = sps_pkg::ST_RCHK;
            sps_pkg::ST_RCHK: n_state = sps_pkg::ST_PUT;
            sps_pkg::ST_FRD: begin
                if ((r_pos >= w_len) || w_over_root) begin
                    n_state = sps_pkg::ST_PUT;
                end else begin
                    n_state = sps_pkg::ST_FCHK;
                end
            end
            sps_pkg::ST_FCHK: begin
                n_state = w_any ? sps_pkg::ST_PUT : sps_pkg::ST_FRD;
            end
            sps_pkg::ST_PUT: begin
                if (w_put) n_state = sps_pkg::ST_IDLE;
            end
            default: n_state = sps_pkg::ST_INIT;
        endcase
    end

    // Outputs of the sequencer: handshake, memory write port, divider start.
    always_comb begin
        o_s_tready  = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_pos[WS +: ADDR_W];
        w_wdata     = r_rdata & ~(WB'(1) << r_pos[WS-1:0]);
        w_rem_start = 1'b0;
        unique case (r_state)
            sps_pkg::ST_INIT, sps_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = '1;
            end
            sps_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                w_rem_start = i_s_tvalid && (w_op == sps_pkg::OP_STRIKE)
                              && (w_arg >= POS_W'(2));
            end
            sps_pkg::ST_SWR: w_we = 1'b1;
            default: ;
        endcase
    end

    assign w_raddr = r_pos[WS +: ADDR_W];

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        r_rdata <= r_map[w_raddr];
    end

    sps_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_base),
        .i_divisor  (i_s_tdata[OW-1:0]),
        .o_stat     (w_rem_stat),
        .o_rem      (w_rem)
    );

    // State register, sweep counter and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sps_pkg::ST_INIT;
            r_addr    <= '0;
            r_base    <= sps_pkg::BASE_RST;
            r_seg_len <= sps_pkg::LENGTH_RST;
            r_root    <= sps_pkg::ROOT_RST;
        end else begin
            r_state <= n_state;
            if ((r_state == sps_pkg::ST_INIT) || (r_state == sps_pkg::ST_CLEAR)) begin
                r_addr <= r_addr + 1'b1;
            end else begin
                r_addr <= '0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sps_pkg::CFG_BASE:   r_base    <= i_cfg_data;
                    sps_pkg::CFG_LENGTH: r_seg_len <= i_cfg_data[sps_pkg::LEN_W-1:0];
                    sps_pkg::CFG_ROOT:   r_root    <= i_cfg_data[sps_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers of the request in progress.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sps_pkg::ST_IDLE: begin
                if (w_accept) begin
                    r_arg      <= i_s_tdata[OW-1:0];
                    r_pos      <= (w_op == sps_pkg::OP_FIND) ? w_arg + 1'b1 : w_arg;
                    r_res_num  <= '0;
                    r_res_hit  <= 1'b0;
                    case (w_op)
                        sps_pkg::OP_STRIKE: r_res_stat <= (w_arg < POS_W'(2));
                        sps_pkg::OP_READ, sps_pkg::OP_FIND: r_res_stat <= w_arg_bad;
                        default: r_res_stat <= 1'b0;
                    endcase
                end
            end
            sps_pkg::ST_DIV: begin
                r_sq <= SQ_W'(r_arg) * SQ_W'(r_arg);
                if (w_rem_stat.done) begin
                    r_first <= (w_rem == '0) ? '0 : r_arg - w_rem;
                end
            end
            sps_pkg::ST_SETUP: r_pos <= w_start[POS_W-1:0];
            sps_pkg::ST_SWR:   r_pos <= w_next_pos;
            sps_pkg::ST_RCHK: begin
                r_res_num <= r_base + NW'(r_pos);
                r_res_hit <= r_rdata[r_pos[WS-1:0]] && !(w_base_zero && (r_pos < POS_W'(2)));
            end
            sps_pkg::ST_FCHK: begin
                if (w_any) begin
                    if (w_cand_ok) begin
                        r_res_num <= w_cand_abs[NW-1:0];
                        r_res_hit <= 1'b1;
                    end
                end else begin
                    r_pos <= w_word_next;
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded from the finished request, emptied by the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_put) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_out_num  <= r_res_num;
            r_out_hit  <= r_res_hit;
            r_out_stat <= r_res_stat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_num;
    assign o_m_tuser  = {r_out_stat, r_out_hit};

    // An accepted request always takes the sequencer out of idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != sps_pkg::ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // A finished request is presented on the result stream in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_put |=> o_m_tvalid)
        else $error("finished result not presented");

    // An error result carries neither a hit nor a number.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (!o_m_tuser[0] && (o_m_tdata == '0)))
        else $error("error result with payload");

    // Strikes only write entries inside the segment in use.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sps_pkg::ST_SWR) |-> (r_pos < w_len))
        else $error("strike outside the segment");

    // The remainder unit is never started while a division is running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rem_start |-> !w_rem_stat.busy)
        else $error("remainder unit restarted while busy");

endmodule

/* hw/rtl/sps_rem.sv */
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle, one step per dividend bit.
module sps_rem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sps_pkg::NUMBER_W-1:0]    i_dividend,
    input  logic [sps_pkg::OPERAND_W-1:0]   i_divisor,
    output sps_pkg::t_rem_stat              o_stat,
    output logic [sps_pkg::OPERAND_W-1:0]   o_rem
);

    localparam int CNT_W = $clog2(sps_pkg::NUMBER_W + 1);

    logic [CNT_W-1:0]                r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [sps_pkg::NUMBER_W-1:0]    r_dvd;
    logic [sps_pkg::OPERAND_W-1:0]   r_div;
    logic [sps_pkg::OPERAND_W-1:0]   r_rem;

    logic [sps_pkg::OPERAND_W:0]     w_trial;
    logic [sps_pkg::OPERAND_W:0]     w_diff;
    logic [sps_pkg::OPERAND_W-1:0]   n_rem;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[sps_pkg::NUMBER_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_diff[sps_pkg::OPERAND_W-1:0];
        end else begin
            n_rem = w_trial[sps_pkg::OPERAND_W-1:0];
        end
    end

    // Control: busy flag, step counter and a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sps_pkg::NUMBER_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Data path of the shift and subtract loop.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[sps_pkg::NUMBER_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

    // The remainder handed out is always below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    // Done follows the last step of a running division only.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running division");

    // The unit is idle in the cycle that it reports a finished division.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still busy");

endmodule
